/* hdl/idsv_pkg.sv */
// ----------------------------------------------------------------------------
// idsv_pkg
// Types and constants shared by the date string checker: word formats,
// status codes, string positions and the month length table.
// ----------------------------------------------------------------------------
package idsv_pkg;

  localparam int STRING_LENGTH = 10;
  localparam int POS_W         = 4;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [POS_W-1:0] POS_MAX      = 4'd15;
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(STRING_LENGTH - 1);
  localparam logic [POS_W-1:0] POS_END      = POS_W'(STRING_LENGTH);
  localparam logic [POS_W-1:0] POS_CENT_END = 4'd2;
  localparam logic [POS_W-1:0] POS_YEAR_END = 4'd4;
  localparam logic [POS_W-1:0] POS_DASH_A   = 4'd4;
  localparam logic [POS_W-1:0] POS_DASH_B   = 4'd7;
  localparam logic [POS_W-1:0] POS_MON_END  = 4'd7;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DASH = 8'h2D;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LENGTH = 2'd1;
  localparam logic [1:0] ST_CHAR   = 2'd2;
  localparam logic [1:0] ST_DATE   = 2'd3;

  typedef struct packed {
    logic [7:0] text_char;
    logic       final_char;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] year_value;
    logic [6:0]  month_value;
    logic [6:0]  day_value;
    logic [26:0] packed_date;
  } out_word_t;

  // one finished string: century and low year digits kept apart
  typedef struct packed {
    logic       len_ok;
    logic       char_err;
    logic [6:0] cent;
    logic [6:0] low;
    logic [6:0] month;
    logic [6:0] day;
  } rec_t;

  function automatic logic [4:0] month_days(input logic [6:0] m);
    logic [4:0] d;
    unique case (m)
      7'd2:                      d = 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

/* hdl/idsv_front.sv */
// ----------------------------------------------------------------------------
// idsv_front
// Character front end: checks each character against the date form,
// accumulates the decimal fields and pushes one record per string.
// ----------------------------------------------------------------------------
module idsv_front import idsv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     char_valid,
  output logic     char_stall,
  input  in_word_t char_data,
  input  logic     queue_full,
  output logic     push,
  output rec_t     push_rec
);

  logic [POS_W-1:0] position, position_next;
  logic [6:0]       cent, cent_next;
  logic [6:0]       low, low_next;
  logic [6:0]       month, month_next;
  logic [6:0]       day, day_next;
  logic             char_err, char_err_next;
  logic             accept;
  logic             digit;
  logic [6:0]       dv;
  logic [7:0]       c;

  assign c          = char_data.text_char;
  assign accept     = char_valid && !queue_full;
  assign char_stall = queue_full;
  assign digit      = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign dv         = {3'd0, 4'(c - CHAR_ZERO)};

  always_comb begin
    cent_next     = cent;
    low_next      = low;
    month_next    = month;
    day_next      = day;
    char_err_next = char_err;
    if (position < POS_END) begin
      priority if (position == POS_DASH_A || position == POS_DASH_B) begin
        if (c != CHAR_DASH) char_err_next = 1'b1;
      end else if (!digit) begin
        char_err_next = 1'b1;
      end else if (position < POS_CENT_END) begin
        cent_next = 7'(cent * 7'd10 + dv);
      end else if (position < POS_YEAR_END) begin
        low_next = 7'(low * 7'd10 + dv);
      end else if (position < POS_MON_END) begin
        month_next = 7'(month * 7'd10 + dv);
      end else begin
        day_next = 7'(day * 7'd10 + dv);
      end
    end
    position_next = (position < POS_MAX) ? position + 4'd1 : position;
  end

  assign push              = accept && char_data.final_char;
  assign push_rec.len_ok   = (position == POS_LAST);
  assign push_rec.char_err = char_err_next;
  assign push_rec.cent     = cent_next;
  assign push_rec.low      = low_next;
  assign push_rec.month    = month_next;
  assign push_rec.day      = day_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      position <= '0;
      cent     <= '0;
      low      <= '0;
      month    <= '0;
      day      <= '0;
      char_err <= 1'b0;
    end else if (accept) begin
      position <= position_next;
      cent     <= cent_next;
      low      <= low_next;
      month    <= month_next;
      day      <= day_next;
      char_err <= char_err_next;
    end
  end

endmodule

/* hdl/idsv_queue.sv */
// ----------------------------------------------------------------------------
// idsv_queue
// Short queue of string records between the front end and the back end.
// ----------------------------------------------------------------------------
module idsv_queue import idsv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  input  logic pop,
  output rec_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rec_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      if (do_pop)  rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      unique case ({do_push, do_pop})
        2'b10:   count <= CNT_W'(count + 1'b1);
        2'b01:   count <= CNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/idsv_back.sv */
// ----------------------------------------------------------------------------
// idsv_back
// Result back end: calendar check and status in the first stage, packed
// value in the second stage, which is also the output register.
// ----------------------------------------------------------------------------
module idsv_back import idsv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  rec_t      head,
  input  logic      empty,
  output logic      pop,
  output logic      result_valid,
  input  logic      result_stall,
  output out_word_t result_data
);

  logic        v1, v2;
  logic        adv2, load1;
  logic [1:0]  st1;
  logic [13:0] year1;
  logic [6:0]  month1, day1;

  logic [13:0] year_c;
  logic        leap;
  logic [4:0]  limit;
  logic        possible;
  logic [1:0]  st_c;
  logic        keep;

  assign adv2  = !v2 || !result_stall;
  assign load1 = !v1 || adv2;
  assign pop   = load1 && !empty;

  assign year_c = 14'(14'(head.cent) * 14'd100) + 14'(head.low);
  assign leap   = ((head.low[1:0] == 2'd0) && (head.low != 7'd0))
               || ((head.low == 7'd0) && (head.cent[1:0] == 2'd0));

  always_comb begin
    limit = month_days(head.month);
    if (head.month == 7'd2 && leap) limit = 5'd29;
    possible = (head.day >= 7'd1) && (head.day <= 7'd31)
            && (head.month >= 7'd1) && (head.month <= 7'd12)
            && (year_c != 14'd0)
            && (head.day <= {2'd0, limit});
    priority if (!head.len_ok) st_c = ST_LENGTH;
    else if (head.char_err)    st_c = ST_CHAR;
    else if (!possible)        st_c = ST_DATE;
    else                       st_c = ST_OK;
  end

  assign keep = (st_c == ST_OK) || (st_c == ST_DATE);

  always_ff @(posedge clk) begin
    if (load1) begin
      st1    <= st_c;
      year1  <= keep ? year_c : 14'd0;
      month1 <= keep ? head.month : 7'd0;
      day1   <= keep ? head.day : 7'd0;
    end
    if (adv2 && v1) begin
      result_data.status      <= st1;
      result_data.year_value  <= year1;
      result_data.month_value <= month1;
      result_data.day_value   <= day1;
      result_data.packed_date <= 27'(27'(year1) * 27'd10000)
                               + 27'(27'(month1) * 27'd100) + 27'(day1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (load1) v1 <= !empty;
      if (adv2)  v2 <= v1;
    end
  end

  assign result_valid = v2;

endmodule

/* hdl/iso_date_string_validator_top.sv */
// A string's record passes from the queue through the first back-end stage into the output register.
// Throughput: one character per cycle while char_stall is low; results leave back to back unless stalled.
// The four-entry record queue sets how far the front runs ahead of a stalled output.
// Reset (rst, synchronous, active high) clears the position count, the
// accumulators, the queue and the output valid.
// ----------------------------------------------------------------------------
// iso_date_string_validator_top
// Date string checker for the form YYYY-MM-DD: front end, record queue and
// result back end.
// ----------------------------------------------------------------------------
module iso_date_string_validator_top import idsv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  output logic      char_stall,
  input  in_word_t  char_data,
  output logic      result_valid,
  input  logic      result_stall,
  output out_word_t result_data
);

  logic push, pop, empty, full;
  rec_t push_rec, head;

  idsv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .queue_full (full),
    .push       (push),
    .push_rec   (push_rec)
  );

  idsv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  idsv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

/* hdl/idsv_checker.sv */
// ----------------------------------------------------------------------------
// idsv_checker
// Port-level checks on the date string checker's result words.
// ----------------------------------------------------------------------------
module idsv_checker import idsv_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input logic      result_stall,
  input out_word_t result_data
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("stalled result word changed");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_data.status == ST_LENGTH || result_data.status == ST_CHAR)
    |-> result_data.year_value == 14'd0 && result_data.month_value == 7'd0
        && result_data.day_value == 7'd0 && result_data.packed_date == 27'd0)
    else $error("rejected string carries nonzero fields");

  a_packed: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_data.packed_date ==
      27'(27'(result_data.year_value) * 27'd10000
          + 27'(result_data.month_value) * 27'd100 + 27'(result_data.day_value)))
    else $error("packed date does not match fields");

  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.status == ST_OK
    |-> result_data.month_value >= 7'd1 && result_data.month_value <= 7'd12
        && result_data.day_value >= 7'd1 && result_data.day_value <= 7'd31
        && result_data.year_value != 14'd0)
    else $error("ok status on an impossible date");

endmodule

bind iso_date_string_validator_top idsv_checker u_idsv_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_data  (result_data)
);

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives YYYY-MM-DD strings one character word at a time into the date string
// checker and compares each result word with a cycle-free model of the
// parser. A typed list of corner strings runs first, then random strings,
// mostly well formed with random content and some broken or pure noise, under
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import idsv_pkg::*;

  localparam int N_DIR      = 24;
  localparam int RAND_CHARS = 1650;
  localparam int HOLD_LEN   = 200;

  logic      clk;
  logic      rst = 1'b1;
  logic      char_valid = 1'b0;
  logic      char_stall;
  in_word_t  char_data = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_word_t result_data;

  iso_date_string_validator_top dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // parser state
  logic [3:0]  pos_now;
  logic [13:0] year_acc;
  logic [6:0]  month_acc;
  logic [6:0]  day_acc;
  logic        bad_seen;

  out_word_t   dates_due[$];
  logic [7:0]  text_buf[$];
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          hold_asked = 0;
  int          hold_taken = 0;
  int          hold_left = 0;
  int          chars_sent = 0;
  int          strings_sent = 0;
  int          fails = 0;
  int          seen_status[4] = '{0, 0, 0, 0};

  string dir_text [N_DIR] = '{
    "2024-02-29", "9999-12-31", "0000-01-01", "0001-01-01", "2023-02-29",
    "1900-02-29", "2000-02-29", "2100-02-28", "2023-04-31", "2023-00-10",
    "2023-01-00", "2023-01-32", "2023-99-99", "2024-0a-01", "2024001-01",
    "/:00-01-01", "2024-13-x1", "20x4-02-3",  "5",          "2024-01-0",
    "2024-01-011", "2024-01-01XXXXXX2024-01-01", "2024-01-0\377", "1999-12-31"
  };

  bit dir_known [N_DIR] = '{
    1, 1, 1, 1, 1,
    0, 0, 0, 0, 1,
    1, 1, 1, 1, 1,
    1, 1, 1, 1, 1,
    1, 1, 1, 0
  };

  out_word_t dir_want [N_DIR] = '{
    '{ST_OK,     14'd2024, 7'd2,  7'd29, 27'd20240229},
    '{ST_OK,     14'd9999, 7'd12, 7'd31, 27'd99991231},
    '{ST_DATE,   14'd0,    7'd1,  7'd1,  27'd101},
    '{ST_OK,     14'd1,    7'd1,  7'd1,  27'd10101},
    '{ST_DATE,   14'd2023, 7'd2,  7'd29, 27'd20230229},
    '0, '0, '0, '0,
    '{ST_DATE,   14'd2023, 7'd0,  7'd10, 27'd20230010},
    '{ST_DATE,   14'd2023, 7'd1,  7'd0,  27'd20230100},
    '{ST_DATE,   14'd2023, 7'd1,  7'd32, 27'd20230132},
    '{ST_DATE,   14'd2023, 7'd99, 7'd99, 27'd20239999},
    '{ST_CHAR,   14'd0,    7'd0,  7'd0,  27'd0},
    '{ST_CHAR,   14'd0,    7'd0,  7'd0,  27'd0},
    '{ST_CHAR,   14'd0,    7'd0,  7'd0,  27'd0},
    '{ST_CHAR,   14'd0,    7'd0,  7'd0,  27'd0},
    '{ST_LENGTH, 14'd0,    7'd0,  7'd0,  27'd0},
    '{ST_LENGTH, 14'd0,    7'd0,  7'd0,  27'd0},
    '{ST_LENGTH, 14'd0,    7'd0,  7'd0,  27'd0},
    '{ST_LENGTH, 14'd0,    7'd0,  7'd0,  27'd0},
    '{ST_LENGTH, 14'd0,    7'd0,  7'd0,  27'd0},
    '{ST_CHAR,   14'd0,    7'd0,  7'd0,  27'd0},
    '0
  };

  function automatic bit calendar_ok(input int y, input int m, input int d);
    bit leap;
    int lim;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      1, 3, 5, 7, 8, 10, 12: lim = 31;
      4, 6, 9, 11:           lim = 30;
      2:                     lim = leap ? 29 : 28;
      default:               return 1'b0;
    endcase
    return (y >= 1) && (d >= 1) && (d <= lim);
  endfunction

  task automatic clear_parser();
    pos_now   = '0;
    year_acc  = '0;
    month_acc = '0;
    day_acc   = '0;
    bad_seen  = 1'b0;
  endtask

  task automatic date_step(input logic [7:0] c, input logic fin, output bit got,
                           output out_word_t w);
    logic [3:0] p;
    logic       dig;
    int         dv;
    p   = pos_now;
    dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    dv  = int'(c) - int'(CHAR_ZERO);
    if (p < POS_END) begin
      if (p == POS_DASH_A || p == POS_DASH_B) begin
        if (c != CHAR_DASH) bad_seen = 1'b1;
      end else if (!dig) begin
        bad_seen = 1'b1;
      end else if (p < POS_YEAR_END) begin
        year_acc = 14'(int'(year_acc) * 10 + dv);
      end else if (p < POS_MON_END) begin
        month_acc = 7'(int'(month_acc) * 10 + dv);
      end else begin
        day_acc = 7'(int'(day_acc) * 10 + dv);
      end
    end
    if (pos_now != POS_MAX) pos_now = pos_now + 4'd1;
    got = fin;
    w   = '0;
    if (fin) begin
      if (p != POS_LAST) w.status = ST_LENGTH;
      else if (bad_seen) w.status = ST_CHAR;
      else if (!calendar_ok(year_acc, month_acc, day_acc)) w.status = ST_DATE;
      else w.status = ST_OK;
      if (w.status == ST_OK || w.status == ST_DATE) begin
        w.year_value  = year_acc;
        w.month_value = month_acc;
        w.day_value   = day_acc;
        w.packed_date = 27'(int'(year_acc) * 10000 + int'(month_acc) * 100 + int'(day_acc));
      end
      clear_parser();
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic fin, input bit typed,
                           input out_word_t want);
    bit        got;
    out_word_t w;
    while ($urandom_range(99) < gap_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_data  <= '{text_char: c, final_char: fin};
    @(posedge clk);
    while (char_stall) @(posedge clk);
    date_step(c, fin, got, w);
    if (got) dates_due.push_back(typed ? want : w);
    chars_sent++;
  endtask

  // drop valid and hold until every date is back
  task automatic drain_dates();
    char_valid <= 1'b0;
    @(posedge clk);
    while (dates_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] noise_char();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return CHAR_ZERO - 8'd1;
      3:       return CHAR_NINE + 8'd1;
      4:       return CHAR_DASH;
      5:       return CHAR_ZERO + 8'($urandom_range(9));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] dec_char(input int v);
    return CHAR_ZERO + 8'(v % 10);
  endfunction

  task automatic make_date_text();
    int y;
    int m;
    int d;
    int r;
    int cut;
    text_buf.delete();
    case ($urandom_range(9))
      0:       y = 0;
      1:       y = 100 * ($urandom_range(3) == 0 ? 4 * $urandom_range(24) : $urandom_range(99));
      2:       y = $urandom_range(1, 9);
      default: y = $urandom_range(9999);
    endcase
    m = ($urandom_range(4) != 0) ? $urandom_range(1, 12) : $urandom_range(99);
    case ($urandom_range(5))
      0:       d = $urandom_range(28, 31);
      1:       d = $urandom_range(0, 1);
      2:       d = $urandom_range(32, 99);
      default: d = $urandom_range(1, 31);
    endcase
    text_buf = {dec_char(y / 1000), dec_char(y / 100), dec_char(y / 10), dec_char(y),
                CHAR_DASH, dec_char(m / 10), dec_char(m), CHAR_DASH,
                dec_char(d / 10), dec_char(d)};
    r = $urandom_range(99);
    if ((r >= 62 && r < 72) || (r >= 84 && r < 92))
      text_buf[$urandom_range(9)] = noise_char();
    if (r >= 72 && r < 92) begin
      if ($urandom_range(1) == 0) begin
        cut = $urandom_range(1, 9);
        while (text_buf.size() > cut) void'(text_buf.pop_back());
      end else begin
        repeat ($urandom_range(1, 20)) text_buf.push_back(noise_char());
      end
    end
    if (r >= 92) begin
      text_buf.delete();
      repeat (($urandom_range(2) == 0) ? 10 : $urandom_range(1, 24))
        text_buf.push_back(noise_char());
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_asked != hold_taken) begin
      result_stall <= 1'b1;
      hold_taken   <= hold_asked;
      hold_left    <= HOLD_LEN;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && result_valid && !result_stall) begin
      if (dates_due.size() == 0) begin
        $error("result word with no date pending: %h", result_data);
        fails++;
      end else begin
        want = dates_due.pop_front();
        seen_status[result_data.status]++;
        if (result_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_data.status);
          fails++;
        end
        if (result_data.year_value !== want.year_value) begin
          $error("year_value: expected %0d, got %0d", want.year_value,
                 result_data.year_value);
          fails++;
        end
        if (result_data.month_value !== want.month_value) begin
          $error("month_value: expected %0d, got %0d", want.month_value,
                 result_data.month_value);
          fails++;
        end
        if (result_data.day_value !== want.day_value) begin
          $error("day_value: expected %0d, got %0d", want.day_value, result_data.day_value);
          fails++;
        end
        if (result_data.packed_date !== want.packed_date) begin
          $error("packed_date: expected %0d, got %0d", want.packed_date,
                 result_data.packed_date);
          fails++;
        end
      end
    end
  end

  initial begin
    int  base;
    int  ph;
    int  i;
    int  k;
    int  n;
    bit  held;
    held = 1'b0;
    clear_parser();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < N_DIR; i++) begin
      n = dir_text[i].len();
      for (k = 0; k < n; k++)
        send_char(dir_text[i][k], k == n - 1, dir_known[i], dir_want[i]);
      strings_sent++;
    end
    drain_dates();

    base = chars_sent;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 84; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 84; end
        default: begin gap_pct = 36; stall_pct = 36; end
      endcase
      while (chars_sent - base < (ph + 1) * RAND_CHARS / 4) begin
        if (ph == 0 && !held && chars_sent - base >= 150) begin
          hold_asked++;
          held = 1'b1;
        end
        make_date_text();
        n = text_buf.size();
        for (k = 0; k < n; k++) send_char(text_buf[k], k == n - 1, 1'b0, '0);
        strings_sent++;
      end
      drain_dates();
    end

    repeat (8) @(posedge clk);
    if (dates_due.size() != 0) begin
      $error("%0d date results never arrived", dates_due.size());
      fails += dates_due.size();
    end
    $display("%0d characters in %0d strings, with sender gaps, receiver stalls and a long hold",
             chars_sent, strings_sent);
    $display("results: %0d ok, %0d wrong length, %0d bad character, %0d impossible date",
             seen_status[ST_OK], seen_status[ST_LENGTH], seen_status[ST_CHAR],
             seen_status[ST_DATE]);
    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
